### rtl/tdca_pkg.sv
package tdca_pkg;

    // Widths fixed by the item fields.
    localparam int TICKS_W   = 21;
    localparam int TS_W      = 48;
    localparam int RDIV_W    = 8;
    localparam int HDIV_W    = 8;
    localparam int RCNT_W    = 9;
    localparam int OUT_W     = 40;
    localparam int WIN_W     = 16;
    localparam int FB_TICK_W = 20;
    localparam int TRIG_W    = 16;
    localparam int PHASE_W   = 3;

    // Configuration port.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam int FRAC_BITS_DEF = 16;

    // Scaled tick product: 21-bit ticks times a 16-bit factor, doubled for low resolution.
    localparam int PROD_W    = TICKS_W + WIN_W + 1;
    // Dividend of the window modulo: four times the timestamp.
    localparam int MOD_NUM_W = TS_W + 2;
    // Divisor width shared by all divider lanes.
    localparam int DEN_W     = FB_TICK_W;

    // Second TDC type constants.
    localparam int PHASE_MOD  = 6;
    localparam int PHASE_STEP = 160;
    localparam int TYPE2_SHR  = 7;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [1:0] {
        PATH_DIV      = 2'd0,
        PATH_FALLBACK = 2'd1,
        PATH_TRIG     = 2'd2,
        PATH_TYPE2    = 2'd3
    } path_t;

    typedef struct packed {
        logic                req_type;
        logic [TICKS_W-1:0]  tdc_ticks;
        logic                low_res_module;
        logic                crate_info_present;
        logic [TS_W-1:0]     clock_timestamp;
        logic                divider_info_present;
        logic [RDIV_W-1:0]   ref_clock_div;
        logic [HDIV_W-1:0]   hs_div;
        logic [RCNT_W-1:0]   ref_count;
    } hit_req_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] time_ns_fx;
        logic                    time_valid;
        path_t                   path_used;
    } hit_rsp_t;

    typedef struct packed {
        logic                 force_fb;
        logic [WIN_W-1:0]     fb_window;
        logic [FB_TICK_W-1:0] fb_ticks;
        logic [TRIG_W-1:0]    trig_ticks;
        logic                 trig_low;
        logic [PHASE_W-1:0]   phase;
    } cfg_t;

    // Item context carried alongside the divider lanes.
    typedef struct packed {
        logic               req_type;
        logic               crate;
        path_t              path;
        logic [WIN_W-1:0]   win;
        logic [TICKS_W-1:0] ticks;
    } side_t;

endpackage

### rtl/tdca_cfg_regs.sv
module tdca_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tdca_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tdca_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tdca_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output tdca_pkg::cfg_t                  cfg
);
    import tdca_pkg::*;

    localparam logic [2:0] REG_FORCE      = 3'd0;
    localparam logic [2:0] REG_FB_WIN     = 3'd1;
    localparam logic [2:0] REG_FB_TICKS   = 3'd2;
    localparam logic [2:0] REG_TRIG_TICKS = 3'd3;
    localparam logic [2:0] REG_TRIG_LOW   = 3'd4;
    localparam logic [2:0] REG_PHASE      = 3'd5;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] idx;

    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[CFG_ADDR_W-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_FORCE:      cfg_next.force_fb   = pwdata[0];
                REG_FB_WIN:     cfg_next.fb_window  = pwdata[WIN_W-1:0];
                REG_FB_TICKS:   cfg_next.fb_ticks   = pwdata[FB_TICK_W-1:0];
                REG_TRIG_TICKS: cfg_next.trig_ticks = pwdata[TRIG_W-1:0];
                REG_TRIG_LOW:   cfg_next.trig_low   = pwdata[0];
                REG_PHASE:      cfg_next.phase      = pwdata[PHASE_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.force_fb   <= 1'b0;
            cfg_reg.fb_window  <= WIN_W'(1);
            cfg_reg.fb_ticks   <= FB_TICK_W'(1);
            cfg_reg.trig_ticks <= '0;
            cfg_reg.trig_low   <= 1'b0;
            cfg_reg.phase      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_FORCE:      prdata = CFG_DATA_W'(cfg_reg.force_fb);
            REG_FB_WIN:     prdata = CFG_DATA_W'(cfg_reg.fb_window);
            REG_FB_TICKS:   prdata = CFG_DATA_W'(cfg_reg.fb_ticks);
            REG_TRIG_TICKS: prdata = CFG_DATA_W'(cfg_reg.trig_ticks);
            REG_TRIG_LOW:   prdata = CFG_DATA_W'(cfg_reg.trig_low);
            REG_PHASE:      prdata = CFG_DATA_W'(cfg_reg.phase);
            default:        prdata = '0;
        endcase
    end

endmodule

### rtl/tdca_div_lane.sv
module tdca_div_lane #(
    parameter int NUM_W = 54,
    parameter int DEN_W = 20
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);

    // Restoring division, one quotient bit per stage. The dividend shifts out
    // at the top while quotient bits shift in at the bottom.
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W-1];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_step
        logic [NUM_W-1:0] n_in;
        logic [DEN_W-1:0] r_in;
        logic [DEN_W-1:0] d_in;
        logic [DEN_W:0]   sh;
        logic [DEN_W:0]   diff;
        logic [NUM_W-1:0] num_next;
        logic [DEN_W-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign n_in = num;
            assign r_in = '0;
            assign d_in = den;
        end
        else
        begin : g_rest
            assign n_in = num_reg[k-1];
            assign r_in = rem_reg[k-1];
            assign d_in = den_reg[k-1];
        end

        assign sh       = {r_in, n_in[NUM_W-1]};
        assign diff     = sh - {1'b0, d_in};
        assign num_next = {n_in[NUM_W-2:0], ~diff[DEN_W]};
        assign rem_next = diff[DEN_W] ? sh[DEN_W-1:0] : diff[DEN_W-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k] <= num_next;
                rem_reg[k] <= rem_next;
            end
        end

        if (k < NUM_W - 1)
        begin : g_den
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[k] <= d_in;
                end
            end
        end
    end

    assign quo = num_reg[NUM_W-1];
    assign rem = rem_reg[NUM_W-1];

endmodule

### rtl/tdca_side_pipe.sv
module tdca_side_pipe #(
    parameter int DEPTH = 54
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  tdca_pkg::side_t in_side,
    output logic            out_valid,
    output tdca_pkg::side_t out_side
);
    import tdca_pkg::*;

    logic [DEPTH-1:0] v_reg;
    logic [DEPTH-1:0] v_next;
    side_t            s_reg [DEPTH];

    assign v_next = {v_reg[DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0] <= in_side;
            for (int k = 1; k < DEPTH; k++)
            begin
                s_reg[k] <= s_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[DEPTH-1];
    assign out_side  = s_reg[DEPTH-1];

endmodule

### rtl/tdca_out_skid.sv
module tdca_out_skid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tdca_pkg::hit_rsp_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output tdca_pkg::hit_rsp_t out_data
);
    import tdca_pkg::*;

    logic     o_v_reg;
    logic     o_v_next;
    logic     s_v_reg;
    logic     s_v_next;
    hit_rsp_t o_reg;
    hit_rsp_t o_next;
    hit_rsp_t s_reg;
    hit_rsp_t s_next;

    assign in_ready  = ~s_v_reg;
    assign out_valid = o_v_reg;
    assign out_data  = o_reg;

    always_comb
    begin
        o_v_next = o_v_reg;
        s_v_next = s_v_reg;
        o_next   = o_reg;
        s_next   = s_reg;
        if (!o_v_reg || out_ready)
        begin
            if (s_v_reg)
            begin
                o_next   = s_reg;
                o_v_next = 1'b1;
                s_v_next = 1'b0;
            end
            else
            begin
                o_next   = in_data;
                o_v_next = in_valid;
            end
        end
        else if (in_valid && !s_v_reg)
        begin
            s_next   = in_data;
            s_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg <= 1'b0;
            s_v_reg <= 1'b0;
        end
        else
        begin
            o_v_reg <= o_v_next;
            s_v_reg <= s_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_reg <= o_next;
        s_reg <= s_next;
    end

endmodule

### rtl/tdc_hit_time_to_ns_aligner.sv
// Channel   Direction  Handshake              Payload
// request   in         req_valid / req_ready  req_data (hit_req_t), one hit per item
// response  out        rsp_valid / rsp_ready  rsp_data (hit_rsp_t), one result per item
// config    in         APB write, pready = 1  paddr, pwdata, prdata
//
// One item is accepted per cycle while the skid entry is free. An item passes stage A,
// the divider lanes, stage C1, stage C2 and the output register in that order. NUM_W is
// the larger of 38 + FRAC_BITS and 50; the divider lanes produce one quotient bit per stage.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// When the response side stalls, the output register holds one result and a skid
// entry catches the next; the whole pipeline then freezes until the skid drains.
module tdc_hit_time_to_ns_aligner #(
    parameter int FRAC_BITS = tdca_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  tdca_pkg::hit_req_t              req_data,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output tdca_pkg::hit_rsp_t              rsp_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tdca_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tdca_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tdca_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import tdca_pkg::*;

    // Every divider lane has the same depth, so the dividends share one width.
    localparam int HIT_NUM_W = PROD_W + FRAC_BITS;
    localparam int NUM_W     = (HIT_NUM_W > MOD_NUM_W) ? HIT_NUM_W : MOD_NUM_W;
    // Signed working width for the differences and the window correction.
    localparam int T_W       = NUM_W + 2;
    // The second type is scaled by 3/128: the divide by 128 becomes a smaller
    // left shift of the fraction alignment.
    localparam int X_SH      = FRAC_BITS - TYPE2_SHR;
    localparam int X_W       = TICKS_W + 3;

    cfg_t cfg;
    logic adv;

    tdca_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The pipeline moves as one whenever the skid entry is free.
    assign req_ready = adv;

    // ---------------------------------------------------------------------
    // Stage A: path choice, scale factors and tick products.
    // ---------------------------------------------------------------------
    logic [WIN_W-1:0]     fw;
    logic [FB_TICK_W-1:0] ft;
    logic [HDIV_W-1:0]    hdiv1;
    logic [RCNT_W:0]      rc2;
    path_t                a_path;
    logic [WIN_W-1:0]     mul_k;
    logic [DEN_W-1:0]     hit_den;
    logic [WIN_W-1:0]     a_win;
    logic [PROD_W-2:0]    prod_hit;
    logic [PROD_W-1:0]    p_hit;
    logic [TRIG_W+WIN_W-1:0] prod_trg;
    logic [PROD_W-1:0]    p_trg;
    side_t                a_side;

    assign fw    = (cfg.fb_window == '0) ? WIN_W'(1) : cfg.fb_window;
    assign ft    = (cfg.fb_ticks == '0) ? FB_TICK_W'(1) : cfg.fb_ticks;
    assign hdiv1 = (req_data.hs_div == '0) ? HDIV_W'(1) : req_data.hs_div;
    assign rc2   = {1'b0, req_data.ref_count} + (RCNT_W + 1)'(2);

    always_comb
    begin
        if (req_data.req_type)
        begin
            a_path = PATH_TYPE2;
        end
        else if (!req_data.crate_info_present)
        begin
            a_path = PATH_TRIG;
        end
        else if (req_data.divider_info_present && !cfg.force_fb)
        begin
            a_path = PATH_DIV;
        end
        else
        begin
            a_path = PATH_FALLBACK;
        end
    end

    // The divider settings give a scale of 4*ref_clock_div / (19*hs_div) and a
    // window of 32*(ref_count+2) ns; otherwise the fallback constants apply.
    always_comb
    begin
        if (a_path == PATH_DIV)
        begin
            mul_k   = WIN_W'({req_data.ref_clock_div, 2'b00});
            hit_den = DEN_W'(hdiv1) * DEN_W'(19);
            a_win   = WIN_W'({rc2, 5'b00000});
        end
        else
        begin
            mul_k   = fw;
            hit_den = ft;
            a_win   = fw;
        end
    end

    assign prod_hit = (PROD_W - 1)'(req_data.tdc_ticks) * (PROD_W - 1)'(mul_k);
    assign p_hit    = req_data.low_res_module ? {prod_hit, 1'b0} : {1'b0, prod_hit};
    assign prod_trg = (TRIG_W + WIN_W)'(cfg.trig_ticks) * (TRIG_W + WIN_W)'(fw);
    assign p_trg    = cfg.trig_low ? PROD_W'({prod_trg, 1'b0}) : PROD_W'(prod_trg);

    assign a_side.req_type = req_data.req_type;
    assign a_side.crate    = req_data.crate_info_present;
    assign a_side.path     = a_path;
    assign a_side.win      = a_win;
    assign a_side.ticks    = req_data.tdc_ticks;

    logic             a_v_reg;
    side_t            a_side_reg;
    logic [NUM_W-1:0] hit_num_reg;
    logic [DEN_W-1:0] hit_den_reg;
    logic [NUM_W-1:0] trg_num_reg;
    logic [DEN_W-1:0] trg_den_reg;
    logic [NUM_W-1:0] mod_num_reg;
    logic [DEN_W-1:0] mod_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= req_valid;
        end
    end

    // The second type needs the timestamp modulo six; the first type needs
    // four times the timestamp modulo the window. Both share the modulo lane.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_side_reg  <= a_side;
            hit_num_reg <= NUM_W'(p_hit) << FRAC_BITS;
            hit_den_reg <= hit_den;
            trg_num_reg <= NUM_W'(p_trg) << FRAC_BITS;
            trg_den_reg <= ft;
            if (req_data.req_type)
            begin
                mod_num_reg <= NUM_W'(req_data.clock_timestamp);
                mod_den_reg <= DEN_W'(PHASE_MOD);
            end
            else
            begin
                mod_num_reg <= NUM_W'({req_data.clock_timestamp, 2'b00});
                mod_den_reg <= DEN_W'(a_win);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Divider lanes: hit scale, trigger reference scale, reference modulo.
    // ---------------------------------------------------------------------
    logic [NUM_W-1:0] hit_q;
    logic [DEN_W-1:0] hit_r;
    logic [NUM_W-1:0] trg_q;
    logic [DEN_W-1:0] trg_r;
    logic [NUM_W-1:0] mod_q;
    logic [DEN_W-1:0] mod_r;
    logic             d_v;
    side_t            d_side;

    tdca_div_lane #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_hit (
        .clk (clk),
        .en  (adv),
        .num (hit_num_reg),
        .den (hit_den_reg),
        .quo (hit_q),
        .rem (hit_r)
    );

    tdca_div_lane #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_trg (
        .clk (clk),
        .en  (adv),
        .num (trg_num_reg),
        .den (trg_den_reg),
        .quo (trg_q),
        .rem (trg_r)
    );

    tdca_div_lane #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_mod (
        .clk (clk),
        .en  (adv),
        .num (mod_num_reg),
        .den (mod_den_reg),
        .quo (mod_q),
        .rem (mod_r)
    );

    tdca_side_pipe #(.DEPTH(NUM_W)) u_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (a_v_reg),
        .in_side   (a_side_reg),
        .out_valid (d_v),
        .out_side  (d_side)
    );

    // ---------------------------------------------------------------------
    // Stage C1: difference against the reference, the second-type time, or zero without crate info.
    // ---------------------------------------------------------------------
    logic [PHASE_W:0] shift_raw;
    logic [PHASE_W:0] shift_fix;
    logic [TICKS_W:0] tick_sum;
    logic [X_W-1:0]   x3;
    logic [T_W-1:0]   sub;
    logic [T_W-1:0]   diff;
    logic [T_W-1:0]   c1_t_next;

    // Only the quotient of the modulo lane and the remainders of the scale
    // lanes are of no use; they are folded into nothing downstream.
    assign shift_raw = {1'b0, cfg.phase} - {1'b0, mod_r[PHASE_W-1:0]};
    assign shift_fix = shift_raw[PHASE_W] ? shift_raw + (PHASE_W + 1)'(PHASE_MOD) : shift_raw;
    assign tick_sum  = (TICKS_W + 1)'(d_side.ticks)
                     + (TICKS_W + 1)'(shift_fix[PHASE_W-1:0]) * (TICKS_W + 1)'(PHASE_STEP);
    assign x3        = X_W'(tick_sum) + X_W'({tick_sum, 1'b0});

    assign sub  = (d_side.path == PATH_TRIG) ? T_W'(trg_q) : (T_W'(mod_r) << FRAC_BITS);
    assign diff = T_W'(hit_q) - sub;

    always_comb
    begin
        if (!d_side.req_type)
        begin
            c1_t_next = diff;
        end
        else if (d_side.crate)
        begin
            c1_t_next = T_W'(x3) << X_SH;
        end
        else
        begin
            c1_t_next = '0;
        end
    end

    logic             c1_v_reg;
    logic [T_W-1:0]   c1_t_reg;
    logic [WIN_W-1:0] c1_win_reg;
    logic             c1_tv_reg;
    path_t            c1_path_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            c1_v_reg <= d_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_t_reg    <= c1_t_next;
            c1_win_reg  <= d_side.win;
            c1_tv_reg   <= ~(d_side.req_type & ~d_side.crate);
            c1_path_reg <= d_side.path;
        end
    end

    // ---------------------------------------------------------------------
    // Stage C2: window correction of a negative difference and saturation.
    // The second-type time is never negative, so it passes unchanged.
    // ---------------------------------------------------------------------
    logic [T_W-1:0]         t2;
    logic [T_W-OUT_W:0]     t2_hi;
    logic signed [OUT_W-1:0] t_sat;
    hit_rsp_t               c2_next;

    assign t2    = c1_t_reg[T_W-1] ? c1_t_reg + (T_W'(c1_win_reg) << FRAC_BITS) : c1_t_reg;
    assign t2_hi = t2[T_W-1:OUT_W-1];

    always_comb
    begin
        if ((&t2_hi) || !(|t2_hi))
        begin
            t_sat = t2[OUT_W-1:0];
        end
        else if (t2[T_W-1])
        begin
            t_sat = OUT_MIN;
        end
        else
        begin
            t_sat = OUT_MAX;
        end
        c2_next.time_ns_fx = t_sat;
        c2_next.time_valid = c1_tv_reg;
        c2_next.path_used  = c1_path_reg;
    end

    logic     c2_v_reg;
    hit_rsp_t c2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            c2_v_reg <= c1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c2_reg <= c2_next;
        end
    end

    // Output register with one skid entry.
    tdca_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c2_v_reg),
        .in_ready  (adv),
        .in_data   (c2_reg),
        .out_valid (rsp_valid),
        .out_ready (rsp_ready),
        .out_data  (rsp_data)
    );

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------

    // The request side stalls only while a finished result is waiting.
    a_stall_has_result : assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid)
        else $error("request stalled with no result waiting");

    // An accepted item occupies the first stage in the next cycle.
    a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> a_v_reg)
        else $error("accepted item did not enter the pipeline");

    // A result marked invalid comes only from the second type and is zero.
    a_invalid_zero : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.time_valid |->
            rsp_data.path_used == PATH_TYPE2 && rsp_data.time_ns_fx == '0)
        else $error("invalid result with wrong path or non-zero time");

    // The skid entry drains only when a result has been taken.
    a_skid_fill : assert property (@(posedge clk) disable iff (!rst_n)
        adv && !$past(adv) |-> $past(rsp_valid && rsp_ready))
        else $error("skid drained without a result being taken");

endmodule
